### rtl/cvd_pkg.sv
// Package for the cascaded vector damper: request and result payload types,
// action and register codes, controller states and the controller command bundle.
// No dependencies; every other file of the block imports it.
package cvd_pkg;

	// Action codes of an input request.
	localparam logic [1:0] ACT_TICK = 2'd0;
	localparam logic [1:0] ACT_FILL = 2'd1;
	localparam logic [1:0] ACT_DEST = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_FILTER_ORDER = 1'b0;
	localparam logic CFG_POINT_COUNT  = 1'b1;

	localparam logic [2:0] FILTER_ORDER_RST = 3'd3;
	localparam logic [4:0] POINT_COUNT_RST  = 5'd1;

	localparam logic [16:0] ALPHA_ONE = 17'd65536;

	// Three Q16.16 components; index 0 is x, 1 is y, 2 is z.
	typedef logic [2:0][31:0] vec_t;

	typedef struct packed {
		logic [1:0]         action;
		logic [3:0]         point_index;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_z;
		logic [16:0]        alpha;
	} in_item_t;

	typedef struct packed {
		logic [3:0]         out_index;
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               last_point;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILL,
		ST_LD_RD,
		ST_LD_WR,
		ST_T_DRD,
		ST_T_DLAT,
		ST_T_MUL,
		ST_T_ADD,
		ST_T_SRD,
		ST_T_S0,
		ST_T_EMIT
	} state_t;

	// Source of the data written to the stage memory.
	typedef enum logic [1:0] {
		WS_INPUT,
		WS_DEST,
		WS_NEW
	} wsrc_t;

	// Source loaded into the running previous-stage register.
	typedef enum logic [1:0] {
		PV_HOLD,
		PV_DEST,
		PV_STAGE,
		PV_NEW
	} prv_t;

	typedef struct packed {
		logic       cap_in;
		logic       dest_we;
		logic       dest_rd;
		logic       stg_we;
		logic       stg_rd;
		wsrc_t      wsrc;
		prv_t       prev_src;
		logic       mul_en;
		logic       out_ld;
		logic [3:0] out_index;
		logic       out_last;
	} cmd_t;

endpackage

### rtl/cvd_ctrl.sv
// Controller of the cascaded vector damper: state machine, point and stage
// counters, configuration registers and the started flag. Uses cvd_pkg.
module cvd_ctrl import cvd_pkg::*; #(
	parameter int MAX_POINTS  = 16,
	parameter int STAGE_COUNT = 5,
	parameter int PW          = 4,
	parameter int SAW         = 7
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [1:0]     action,
	input  logic [3:0]     point_index,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [4:0]     cfg_wdata,
	input  logic           out_room,
	output cmd_t           cmd,
	output logic [PW-1:0]  pt_addr,
	output logic [SAW-1:0] stg_addr
);

	localparam int CW = (PW + 1 > 5) ? PW + 1 : 5;

	state_t        state_q, state_d;
	logic [PW-1:0] p_q;
	logic [2:0]    s_q;
	logic          started_q;
	logic [2:0]    filter_order_q;
	logic [4:0]    point_count_q;

	logic          accept;
	logic          in_range;
	logic [2:0]    used;
	logic [CW-1:0] count_eff;
	logic [CW-1:0] pc_ext;
	logic          p_last_tick;
	logic          p_last_all;
	logic          s_last_sc;
	logic          s_more;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign in_range = int'(point_index) < MAX_POINTS;

	assign used = (filter_order_q > 3'(STAGE_COUNT)) ? 3'(STAGE_COUNT) : filter_order_q;

	assign pc_ext = CW'(point_count_q);
	always_comb begin
		if (pc_ext == '0) begin
			count_eff = CW'(1);
		end else if (pc_ext > CW'(MAX_POINTS)) begin
			count_eff = CW'(MAX_POINTS);
		end else begin
			count_eff = pc_ext;
		end
	end

	assign p_last_tick = (CW'(p_q) + CW'(1)) == count_eff;
	assign p_last_all  = p_q == PW'(MAX_POINTS - 1);
	assign s_last_sc   = s_q == 3'(STAGE_COUNT - 1);
	assign s_more      = (s_q + 3'd1) < used;

	assign pt_addr  = (state_q == ST_IDLE) ? PW'(point_index) : p_q;
	assign stg_addr = SAW'(SAW'(p_q) * SAW'(STAGE_COUNT)) + SAW'(s_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_order_q <= FILTER_ORDER_RST;
			point_count_q  <= POINT_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FILTER_ORDER: filter_order_q <= cfg_wdata[2:0];
				CFG_POINT_COUNT:  point_count_q  <= cfg_wdata;
				default:          ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (action == ACT_TICK) begin
						state_d = started_q ? ST_T_DRD : ST_LD_RD;
					end else if (action == ACT_FILL && in_range) begin
						state_d = ST_FILL;
					end
				end
			end
			ST_FILL:   state_d = s_last_sc ? ST_IDLE : ST_FILL;
			ST_LD_RD:  state_d = ST_LD_WR;
			ST_LD_WR: begin
				if (s_last_sc) begin
					state_d = p_last_all ? ST_IDLE : ST_LD_RD;
				end
			end
			ST_T_DRD:  state_d = ST_T_DLAT;
			ST_T_DLAT: state_d = (used == 3'd0) ? ST_T_S0 : ST_T_MUL;
			ST_T_MUL:  state_d = ST_T_ADD;
			ST_T_ADD:  state_d = s_more ? ST_T_SRD : ST_T_EMIT;
			ST_T_SRD:  state_d = ST_T_MUL;
			ST_T_S0:   state_d = ST_T_EMIT;
			ST_T_EMIT: begin
				if (out_room) begin
					state_d = p_last_tick ? ST_IDLE : ST_T_DRD;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.wsrc      = WS_INPUT;
		cmd.prev_src  = PV_HOLD;
		cmd.out_index = 4'(p_q);
		cmd.out_last  = p_last_tick;
		case (state_q)
			ST_IDLE: begin
				cmd.cap_in  = accept;
				cmd.dest_we = accept && (action == ACT_DEST) && in_range;
			end
			ST_FILL: begin
				cmd.stg_we = 1'b1;
				cmd.wsrc   = WS_INPUT;
			end
			ST_LD_RD:  cmd.dest_rd = 1'b1;
			ST_LD_WR: begin
				cmd.stg_we = 1'b1;
				cmd.wsrc   = WS_DEST;
			end
			ST_T_DRD:  cmd.dest_rd = 1'b1;
			ST_T_DLAT: begin
				cmd.prev_src = PV_DEST;
				cmd.stg_rd   = 1'b1;
			end
			ST_T_MUL:  cmd.mul_en = 1'b1;
			ST_T_ADD: begin
				cmd.stg_we   = 1'b1;
				cmd.wsrc     = WS_NEW;
				cmd.prev_src = PV_NEW;
			end
			ST_T_SRD:  cmd.stg_rd = 1'b1;
			ST_T_S0:   cmd.prev_src = PV_STAGE;
			ST_T_EMIT: cmd.out_ld = out_room;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			p_q       <= '0;
			s_q       <= '0;
			started_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						s_q <= '0;
						if (action == ACT_TICK) begin
							p_q       <= '0;
							started_q <= 1'b1;
						end else begin
							p_q <= PW'(point_index);
						end
					end
				end
				ST_FILL:   s_q <= s_q + 3'd1;
				ST_LD_WR: begin
					if (s_last_sc) begin
						s_q <= '0;
						p_q <= p_q + PW'(1);
					end else begin
						s_q <= s_q + 3'd1;
					end
				end
				ST_T_DRD:  s_q <= '0;
				ST_T_ADD: begin
					if (s_more) begin
						s_q <= s_q + 3'd1;
					end
				end
				ST_T_EMIT: begin
					if (out_room && !p_last_tick) begin
						p_q <= p_q + PW'(1);
					end
				end
				default:   ;
			endcase
		end
	end

endmodule

### rtl/cvd_dp.sv
// Datapath of the cascaded vector damper: destination and stage memories, the
// three-lane multiply and round unit, and the result register. Uses cvd_pkg.
module cvd_dp import cvd_pkg::*; #(
	parameter int MAX_POINTS  = 16,
	parameter int STAGE_COUNT = 5,
	parameter int PW          = 4,
	parameter int SAW         = 7
) (
	input  logic           clk,
	input  logic           arst_n,
	input  in_item_t       in_data,
	input  cmd_t           cmd,
	input  logic [PW-1:0]  pt_addr,
	input  logic [SAW-1:0] stg_addr,
	input  logic           out_stall,
	output logic           out_room,
	output logic           out_valid,
	output out_item_t      out_data
);

	localparam int STG_ROWS = MAX_POINTS * STAGE_COUNT;

	vec_t dest_mem [MAX_POINTS];
	vec_t stg_mem [STG_ROWS];

	logic [MAX_POINTS-1:0] dest_vld_q;
	vec_t                  dest_rd_q;
	logic                  dest_rv_q;
	vec_t                  stg_rd_q;
	vec_t                  coord_q;
	logic [16:0]           alpha_q;
	vec_t                  prev_q;
	logic signed [50:0]    prod_s1 [3];
	out_item_t             out_q;
	logic                  out_valid_q;

	vec_t                  in_vec;
	vec_t                  dest_val;
	vec_t                  new_val;
	vec_t                  stg_wdata;
	logic signed [32:0]    diff [3];
	logic signed [50:0]    rnd [3];

	assign in_vec = {in_data.coord_z, in_data.coord_y, in_data.coord_x};

	// A destination never written since reset reads as zero.
	assign dest_val = dest_rv_q ? dest_rd_q : '0;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			diff[c]    = {stg_rd_q[c][31], stg_rd_q[c]} - {prev_q[c][31], prev_q[c]};
			rnd[c]     = prod_s1[c] + 51'sd32768;
			new_val[c] = prev_q[c] + rnd[c][47:16];
		end
	end

	always_comb begin
		case (cmd.wsrc)
			WS_INPUT: stg_wdata = coord_q;
			WS_DEST:  stg_wdata = dest_val;
			WS_NEW:   stg_wdata = new_val;
			default:  stg_wdata = coord_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_vld_q <= '0;
		end else if (cmd.dest_we) begin
			dest_vld_q[pt_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.dest_we) begin
			dest_mem[pt_addr] <= in_vec;
		end
		if (cmd.dest_rd) begin
			dest_rd_q <= dest_mem[pt_addr];
			dest_rv_q <= dest_vld_q[pt_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.stg_we) begin
			stg_mem[stg_addr] <= stg_wdata;
		end
		if (cmd.stg_rd) begin
			stg_rd_q <= stg_mem[stg_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			coord_q <= in_vec;
			alpha_q <= (in_data.alpha > ALPHA_ONE) ? ALPHA_ONE : in_data.alpha;
		end
		if (cmd.mul_en) begin
			for (int c = 0; c < 3; c++) begin
				prod_s1[c] <= diff[c] * $signed({1'b0, alpha_q});
			end
		end
		case (cmd.prev_src)
			PV_DEST:  prev_q <= dest_val;
			PV_STAGE: prev_q <= stg_rd_q;
			PV_NEW:   prev_q <= new_val;
			default:  ;
		endcase
		if (cmd.out_ld) begin
			out_q.out_index  <= cmd.out_index;
			out_q.out_x      <= prev_q[0];
			out_q.out_y      <= prev_q[1];
			out_q.out_z      <= prev_q[2];
			out_q.last_point <= cmd.out_last;
		end
	end

	assign out_room = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### rtl/cascaded_vector_damper.sv
// Top level of the cascaded vector damper: joins the controller and the datapath.
// Depends on cvd_pkg, cvd_ctrl and cvd_dp.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall  | in_data (in_item_t)
//   out     | output    | out_valid / out_stall| out_data (out_item_t)
//   cfg     | input     | cfg_we               | cfg_index, cfg_wdata
//
// A destination write is taken while idle and leaves the input free; a write to all
// stages of a point fills them in turn; the first tick sweeps the stage memory, reading
// each point's destination and writing it to every stage of that point.
// A later tick steps through each point of the run and each stage in use: read the
// stage, multiply, then round and write back, as the stage memory is single-ported.
// Reset clears the control state and marks every destination as zero.
// A stalled result waits in the output register; the next point is held until it leaves.
module cascaded_vector_damper import cvd_pkg::*; #(
	parameter int MAX_POINTS  = 16,
	parameter int STAGE_COUNT = 5
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data,
	input  logic      cfg_we,
	input  logic      cfg_index,
	input  logic [4:0] cfg_wdata
);

	localparam int PW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int SAW = (MAX_POINTS * STAGE_COUNT > 1) ? $clog2(MAX_POINTS * STAGE_COUNT) : 1;

	cmd_t           cmd;
	logic [PW-1:0]  pt_addr;
	logic [SAW-1:0] stg_addr;
	logic           out_room;

	cvd_ctrl #(
		.MAX_POINTS (MAX_POINTS),
		.STAGE_COUNT(STAGE_COUNT),
		.PW         (PW),
		.SAW        (SAW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (in_data.action),
		.point_index(in_data.point_index),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.out_room   (out_room),
		.cmd        (cmd),
		.pt_addr    (pt_addr),
		.stg_addr   (stg_addr)
	);

	cvd_dp #(
		.MAX_POINTS (MAX_POINTS),
		.STAGE_COUNT(STAGE_COUNT),
		.PW         (PW),
		.SAW        (SAW)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.pt_addr  (pt_addr),
		.stg_addr (stg_addr),
		.out_stall(out_stall),
		.out_room (out_room),
		.out_valid(out_valid),
		.out_data (out_data)
	);

endmodule

### rtl/cvd_checker.sv
// Port-level checks for the cascaded vector damper, bound to its top level.
// Depends on cvd_pkg and cascaded_vector_damper.
module cvd_checker import cvd_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	// A stalled result stays put.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// Every tick request leaves the block busy, holding off the input.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.action == ACT_TICK |=> in_stall)
		else $error("tick request did not hold off the input");

	// A destination write completes in the cycle it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.action == ACT_DEST |=> !in_stall)
		else $error("destination write held off the input");

	// Results only appear while a tick is being worked through.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared while idle");

	// A result directly after the last of a run can only be the first of the next run.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_data.last_point |=>
			!out_valid || out_data.out_index == 4'd0)
		else $error("result after the last of a run did not open a new run");

endmodule

bind cascaded_vector_damper cvd_checker u_cvd_checker (.*);

### verif/cvd_damper_checker.sv
// Checker for the cascaded vector damper: follows the request, result and register ports,
// keeps its own copy of the destinations and smoothing stages, and compares every result.
// Depends on cvd_pkg for the payload types, action codes and register indexes.
module cvd_damper_checker import cvd_pkg::*; #(
	parameter int MAX_POINTS  = 16,
	parameter int STAGE_COUNT = 5
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  in_item_t   in_data,
	input  logic       out_valid,
	input  logic       out_stall,
	input  out_item_t  out_data,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [4:0] cfg_wdata,
	output int         failures,
	output int         pending
);

	logic [31:0] dest_mem [MAX_POINTS][3];
	logic [31:0] stage_mem [MAX_POINTS][STAGE_COUNT][3];
	logic        stages_loaded;
	logic [2:0]  order_reg;
	logic [4:0]  count_reg;
	out_item_t   smoothed_points [$];
	out_item_t   oldest;
	int          mismatches;

	// One smoothing step: prev + round((stage - prev) * alpha / 2^16), ties upwards.
	function automatic logic [31:0] damp_toward(input logic [31:0] stage,
			input logic [31:0] prev, input logic [16:0] alpha);
		logic signed [63:0] diff;
		logic signed [63:0] prod;
		logic signed [63:0] quot;
		diff = $signed(stage) - $signed(prev);
		prod = diff * $signed({47'd0, alpha}) + 64'sd32768;
		quot = prod >>> 16;
		return prev + quot[31:0];
	endfunction

	task automatic apply_request(input in_item_t req);
		vec_t        coord;
		logic [16:0] alpha;
		int          used;
		int          sel;
		int          cnt;
		out_item_t   res;
		coord[0] = req.coord_x;
		coord[1] = req.coord_y;
		coord[2] = req.coord_z;
		case (req.action)
			ACT_DEST: begin
				for (int c = 0; c < 3; c++)
					dest_mem[req.point_index][c] = coord[c];
			end
			ACT_FILL: begin
				for (int s = 0; s < STAGE_COUNT; s++)
					for (int c = 0; c < 3; c++)
						stage_mem[req.point_index][s][c] = coord[c];
			end
			ACT_TICK: begin
				if (!stages_loaded) begin
					// The first tick only loads every stage of every point.
					stages_loaded = 1'b1;
					for (int p = 0; p < MAX_POINTS; p++)
						for (int s = 0; s < STAGE_COUNT; s++)
							for (int c = 0; c < 3; c++)
								stage_mem[p][s][c] = dest_mem[p][c];
				end else begin
					alpha = (req.alpha > ALPHA_ONE) ? ALPHA_ONE : req.alpha;
					used = (order_reg > STAGE_COUNT) ? STAGE_COUNT : order_reg;
					sel = (used == 0) ? 0 : used - 1;
					cnt = (count_reg == 0) ? 1 : count_reg;
					if (cnt > MAX_POINTS)
						cnt = MAX_POINTS;
					for (int p = 0; p < cnt; p++) begin
						for (int s = 0; s < used; s++)
							for (int c = 0; c < 3; c++)
								stage_mem[p][s][c] = damp_toward(stage_mem[p][s][c],
									(s == 0) ? dest_mem[p][c] : stage_mem[p][s - 1][c], alpha);
						res.out_index  = p[3:0];
						res.out_x      = stage_mem[p][sel][0];
						res.out_y      = stage_mem[p][sel][1];
						res.out_z      = stage_mem[p][sel][2];
						res.last_point = (p + 1 == cnt);
						smoothed_points.push_back(res);
					end
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < MAX_POINTS; p++)
				for (int c = 0; c < 3; c++) begin
					dest_mem[p][c] = '0;
					for (int s = 0; s < STAGE_COUNT; s++)
						stage_mem[p][s][c] = '0;
				end
			stages_loaded = 1'b0;
			order_reg = FILTER_ORDER_RST;
			count_reg = POINT_COUNT_RST;
			smoothed_points.delete();
			mismatches = 0;
			failures <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_FILTER_ORDER)
					order_reg = cfg_wdata[2:0];
				else
					count_reg = cfg_wdata;
			end
			if (in_valid && !in_stall)
				apply_request(in_data);
			if (out_valid && !out_stall) begin
				if (smoothed_points.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result: index %0d x %h y %h z %h last %b",
							out_data.out_index, out_data.out_x, out_data.out_y,
							out_data.out_z, out_data.last_point);
					mismatches++;
				end else begin
					oldest = smoothed_points.pop_front();
					if (out_data.out_index !== oldest.out_index || out_data.out_x !== oldest.out_x
							|| out_data.out_y !== oldest.out_y || out_data.out_z !== oldest.out_z
							|| out_data.last_point !== oldest.last_point) begin
						if (mismatches < 10) begin
							$display("mismatch: expected index %0d x %h y %h z %h last %b",
								oldest.out_index, oldest.out_x, oldest.out_y, oldest.out_z,
								oldest.last_point);
							$display("          actual   index %0d x %h y %h z %h last %b",
								out_data.out_index, out_data.out_x, out_data.out_y,
								out_data.out_z, out_data.last_point);
						end
						mismatches++;
					end
				end
			end
			failures <= mismatches;
			pending <= smoothed_points.size();
		end
	end

endmodule

### verif/cascaded_vector_damper_tb.sv
// Testbench top for the cascaded vector damper: clock, reset, register writes and requests
// under several idling patterns; the verdict comes from cvd_damper_checker.
// Depends on cvd_pkg, cascaded_vector_damper and cvd_damper_checker.
module cascaded_vector_damper_tb;
	import cvd_pkg::*;

	localparam logic [1:0] ACT_NONE = 2'd3;
	localparam int SETTLE_CYCLES = 120;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 14;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	in_item_t   in_data = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_item_t  out_data;
	logic       cfg_we = 1'b0;
	logic       cfg_index = CFG_FILTER_ORDER;
	logic [4:0] cfg_wdata = '0;

	int failures;
	int pending;
	int cycles = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int phase_order [PHASES] = '{0, 5, 7, 1, 6, 2, 4, 3};
	int phase_count [PHASES] = '{0, 16, 31, 17, 2, 8, 5, 1};

	cascaded_vector_damper uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	cvd_damper_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.failures  (failures),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0000;
			4, 5: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [16:0] pick_alpha();
		case ($urandom_range(9))
			0: return 17'd0;
			1: return ALPHA_ONE;
			2: return 17'($urandom_range(131071, 65537));
			default: return 17'($urandom_range(65536));
		endcase
	endfunction

	// Mostly writes to points in use, mixed with ticks; a few requests carry the unused action.
	function automatic in_item_t make_request(input int points_in_use);
		in_item_t req;
		int roll;
		roll = $urandom_range(99);
		if (roll < 38)
			req.action = ACT_TICK;
		else if (roll < 70)
			req.action = ACT_DEST;
		else if (roll < 92)
			req.action = ACT_FILL;
		else
			req.action = ACT_NONE;
		if ($urandom_range(3) != 0)
			req.point_index = 4'($urandom_range(points_in_use - 1));
		else
			req.point_index = 4'($urandom_range(15));
		req.coord_x = pick_coord();
		req.coord_y = pick_coord();
		req.coord_z = pick_coord();
		req.alpha = pick_alpha();
		return req;
	endfunction

	// Called at a rising edge; returns at the edge where the request is taken.
	task automatic send_request(input in_item_t req);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		in_data <= req;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
	endtask

	task automatic push_request(input logic [1:0] act, input logic [3:0] idx,
			input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
			input logic [16:0] alpha);
		in_item_t req;
		req.action = act;
		req.point_index = idx;
		req.coord_x = x;
		req.coord_y = y;
		req.coord_z = z;
		req.alpha = alpha;
		send_request(req);
	endtask

	// Requests with no result may still be in progress, e.g. the first tick's sweep.
	task automatic settle();
		in_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The enable drops after each write, so back-to-back writes stay apart.
	task automatic write_register(input logic idx, input logic [4:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int points_in_use;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		write_register(CFG_FILTER_ORDER, 5'd5);
		write_register(CFG_POINT_COUNT, 5'd3);
		// Writes before the first tick are kept, but that tick reloads every stage.
		push_request(ACT_DEST, 4'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 17'd0);
		push_request(ACT_DEST, 4'd1, 32'hFFFF_FFFF, 32'h0001_0000, 32'h8000_0000, 17'd0);
		push_request(ACT_DEST, 4'd2, 32'h1234_5678, 32'hEDCB_A988, 32'h7FFF_FFFF, 17'd0);
		push_request(ACT_FILL, 4'd1, 32'd1, 32'd2, 32'd3, 17'd0);
		push_request(ACT_NONE, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			17'h1FFFF);
		push_request(ACT_TICK, 4'd0, 32'h0, 32'h0, 32'h0, 17'd0);
		push_request(ACT_TICK, 4'd15, 32'hFFFF_FFFF, 32'h0, 32'h0, 17'd0);
		push_request(ACT_FILL, 4'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 17'd0);
		push_request(ACT_FILL, 4'd2, 32'h0, 32'h0, 32'h0, 17'd0);
		push_request(ACT_TICK, 4'd0, 32'h0, 32'h0, 32'h0, 17'd65535);
		push_request(ACT_TICK, 4'd0, 32'h0, 32'h0, 32'h0, ALPHA_ONE);
		push_request(ACT_TICK, 4'd0, 32'h0, 32'h0, 32'h0, 17'h1FFFF);
		push_request(ACT_FILL, 4'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 17'd0);
		push_request(ACT_FILL, 4'd1, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 17'd0);
		push_request(ACT_TICK, 4'd0, 32'h0, 32'h0, 32'h0, 17'd32768);
		push_request(ACT_DEST, 4'd15, 32'h0101_0101, 32'hF0F0_F0F0, 32'h5555_5555, 17'd0);
		push_request(ACT_FILL, 4'd14, 32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC, 17'd0);
		push_request(ACT_TICK, 4'd0, 32'h0, 32'h0, 32'h0, 17'd1);
		push_request(ACT_NONE, 4'd0, 32'h0, 32'h0, 32'h0, 17'd0);
		push_request(ACT_DEST, 4'd2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 17'd0);
		push_request(ACT_TICK, 4'd0, 32'h0, 32'h0, 32'h0, 17'd49152);

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			write_register(CFG_FILTER_ORDER, phase_order[ph][4:0]);
			write_register(CFG_POINT_COUNT, phase_count[ph][4:0]);
			points_in_use = (phase_count[ph] == 0) ? 1 :
				(phase_count[ph] > 16) ? 16 : phase_count[ph];
			case (ph % 4)
				0: begin
					send_idle_pct <= 0;
					stall_pct <= 0;
				end
				1: begin
					send_idle_pct <= 45;
					stall_pct <= 0;
				end
				2: begin
					send_idle_pct <= 0;
					stall_pct <= 45;
				end
				default: begin
					send_idle_pct <= 25;
					stall_pct <= 25;
				end
			endcase
			repeat (ITEMS_PER_PHASE)
				send_request(make_request(points_in_use));
		end
		settle();

		if (failures == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### sim.f
rtl/cvd_pkg.sv
rtl/cvd_ctrl.sv
rtl/cvd_dp.sv
rtl/cascaded_vector_damper.sv
rtl/cvd_checker.sv
verif/cvd_damper_checker.sv
verif/cascaded_vector_damper_tb.sv
